[src/assert_macros.svh]
// Assertion macros shared by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define FKHC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fkhc: invariant violated");

// Same-cycle implication.
`define FKHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fkhc: implication violated");

// Next-cycle implication.
`define FKHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fkhc: next-cycle implication violated");

`endif

[src/fkhc_pkg.sv]
// Types and constants shared by the keyed handle cache modules.
`timescale 1ns / 1ps

package fkhc_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 7;
  localparam int CMD_W           = 2;
  localparam int KIND_W          = 3;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CAP_W-1:0]         CAP_RESET        = 7'd64;
  localparam logic [CFG_IDX_W-1:0]     CFG_REG_CAPACITY = 1'b0;
  localparam logic signed [DATA_W-1:0] STREAM_NONE      = -32'sd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MISS    = 3'd0,
    KIND_HIT     = 3'd1,
    KIND_STORED  = 3'd2,
    KIND_IGNORED = 3'd3,
    KIND_RELEASE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    SRC_ZERO      = 2'd0,
    SRC_RD_HANDLE = 2'd1,
    SRC_RD_BOTH   = 2'd2,
    SRC_IN_HANDLE = 2'd3
  } out_src_t;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_DISPATCH   = 4'd1,
    ST_SCAN       = 4'd2,
    ST_EMIT       = 4'd3,
    ST_EVICT_RD   = 4'd4,
    ST_EVICT_EMIT = 4'd5,
    ST_STORE      = 4'd6,
    ST_CLR_RD     = 4'd7,
    ST_CLR_EMIT   = 4'd8
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch_in;
    logic     scan_start;
    logic     rd_issue;
    logic     rd_oldest;
    logic     evict;
    logic     store;
    logic     clr_done;
    logic     out_load;
    kind_t    out_kind;
    out_src_t out_src;
    logic     out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic cacheable;
    logic handle_nz;
    logic key_match;
    logic full;
    logic left_zero;
    logic out_free;
  } dp_stat_t;

endpackage

[src/fkhc_if.sv]
// Valid/ready channel interfaces for the cache's request and result items.
`timescale 1ns / 1ps

interface fkhc_in_if;
  logic                               valid;
  logic                               ready;
  logic [fkhc_pkg::CMD_W-1:0]         command;
  logic                               blend_base_present;
  logic signed [fkhc_pkg::DATA_W-1:0] stream_id;
  logic [fkhc_pkg::DATA_W-1:0]        item_key;
  logic [fkhc_pkg::DATA_W-1:0]        handle_in;
  logic [fkhc_pkg::DATA_W-1:0]        id_in;

  modport source (
    output valid, command, blend_base_present, stream_id, item_key, handle_in, id_in,
    input  ready
  );
  modport sink (
    input  valid, command, blend_base_present, stream_id, item_key, handle_in, id_in,
    output ready
  );
endinterface

interface fkhc_out_if;
  logic                        valid;
  logic                        ready;
  logic [fkhc_pkg::KIND_W-1:0] result_kind;
  logic [fkhc_pkg::DATA_W-1:0] handle_out;
  logic [fkhc_pkg::DATA_W-1:0] id_out;
  logic                        last;

  modport source (
    output valid, result_kind, handle_out, id_out, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, handle_out, id_out, last,
    output ready
  );
endinterface

[src/fkhc_ctrl.sv]
// Controller state machine sequencing lookups, inserts and clears.
`timescale 1ns / 1ps

module fkhc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fkhc_pkg::dp_stat_t stat,
  output fkhc_pkg::dp_cmd_t  cmd
);

  fkhc_pkg::state_t state_r, state_nxt;
  fkhc_pkg::kind_t  kind_r, kind_nxt;
  logic             pend_r, pend_nxt;
  logic             found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fkhc_pkg::ST_IDLE;
      kind_r  <= fkhc_pkg::KIND_MISS;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign found = pend_r && stat.key_match;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    pend_nxt  = 1'b0;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.out_kind = fkhc_pkg::KIND_MISS;
    cmd.out_src  = fkhc_pkg::SRC_ZERO;

    case (state_r)
      fkhc_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_nxt = fkhc_pkg::ST_DISPATCH;
        end
      end

      fkhc_pkg::ST_DISPATCH: begin
        case (stat.cmd)
          fkhc_pkg::CMD_LOOKUP: begin
            if (stat.cacheable) begin
              cmd.scan_start = 1'b1;
              state_nxt      = fkhc_pkg::ST_SCAN;
            end else begin
              kind_nxt  = fkhc_pkg::KIND_MISS;
              state_nxt = fkhc_pkg::ST_EMIT;
            end
          end
          fkhc_pkg::CMD_INSERT: begin
            if (stat.cacheable && stat.handle_nz) begin
              cmd.scan_start = 1'b1;
              state_nxt      = fkhc_pkg::ST_SCAN;
            end else begin
              kind_nxt  = fkhc_pkg::KIND_IGNORED;
              state_nxt = fkhc_pkg::ST_EMIT;
            end
          end
          fkhc_pkg::CMD_CLEAR: begin
            cmd.scan_start = 1'b1;
            state_nxt      = fkhc_pkg::ST_CLR_RD;
          end
          default: begin
            kind_nxt  = fkhc_pkg::KIND_MISS;
            state_nxt = fkhc_pkg::ST_EMIT;
          end
        endcase
      end

      fkhc_pkg::ST_SCAN: begin
        if (found) begin
          kind_nxt  = (stat.cmd == fkhc_pkg::CMD_LOOKUP) ? fkhc_pkg::KIND_HIT
                                                         : fkhc_pkg::KIND_IGNORED;
          state_nxt = fkhc_pkg::ST_EMIT;
        end else if (stat.left_zero) begin
          if (stat.cmd == fkhc_pkg::CMD_LOOKUP) begin
            kind_nxt  = fkhc_pkg::KIND_MISS;
            state_nxt = fkhc_pkg::ST_EMIT;
          end else if (stat.full) begin
            state_nxt = fkhc_pkg::ST_EVICT_RD;
          end else begin
            state_nxt = fkhc_pkg::ST_STORE;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          pend_nxt     = 1'b1;
        end
      end

      fkhc_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = kind_r;
          cmd.out_src  = (kind_r == fkhc_pkg::KIND_HIT) ? fkhc_pkg::SRC_RD_BOTH
                                                        : fkhc_pkg::SRC_ZERO;
          cmd.out_last = 1'b1;
          state_nxt    = fkhc_pkg::ST_IDLE;
        end
      end

      fkhc_pkg::ST_EVICT_RD: begin
        cmd.rd_oldest = 1'b1;
        state_nxt     = fkhc_pkg::ST_EVICT_EMIT;
      end

      fkhc_pkg::ST_EVICT_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = fkhc_pkg::KIND_RELEASE;
          cmd.out_src  = fkhc_pkg::SRC_RD_HANDLE;
          cmd.evict    = 1'b1;
          state_nxt    = fkhc_pkg::ST_STORE;
        end
      end

      fkhc_pkg::ST_STORE: begin
        if (stat.out_free) begin
          cmd.store    = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_kind = fkhc_pkg::KIND_STORED;
          cmd.out_src  = fkhc_pkg::SRC_IN_HANDLE;
          cmd.out_last = 1'b1;
          state_nxt    = fkhc_pkg::ST_IDLE;
        end
      end

      fkhc_pkg::ST_CLR_RD: begin
        if (stat.left_zero) begin
          cmd.clr_done = 1'b1;
          state_nxt    = fkhc_pkg::ST_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = fkhc_pkg::ST_CLR_EMIT;
        end
      end

      fkhc_pkg::ST_CLR_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = fkhc_pkg::KIND_RELEASE;
          cmd.out_src  = fkhc_pkg::SRC_RD_HANDLE;
          cmd.out_last = stat.left_zero;
          state_nxt    = fkhc_pkg::ST_CLR_RD;
        end
      end

      default: begin
        state_nxt = fkhc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/fkhc_dp.sv]
// Datapath: entry memories, ring pointers, scan counter and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fkhc_dp #(
  parameter int MAX_ENTRIES = fkhc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fkhc_pkg::dp_cmd_t                  cmd,
  output fkhc_pkg::dp_stat_t                 stat,
  input  logic [fkhc_pkg::CAP_W-1:0]         capacity,
  input  logic [fkhc_pkg::CMD_W-1:0]         in_command,
  input  logic                               in_blend,
  input  logic signed [fkhc_pkg::DATA_W-1:0] in_stream_id,
  input  logic [fkhc_pkg::DATA_W-1:0]        in_key,
  input  logic [fkhc_pkg::DATA_W-1:0]        in_handle,
  input  logic [fkhc_pkg::DATA_W-1:0]        in_id,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fkhc_pkg::KIND_W-1:0]        out_kind,
  output logic [fkhc_pkg::DATA_W-1:0]        out_handle,
  output logic [fkhc_pkg::DATA_W-1:0]        out_id,
  output logic                               out_last
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > fkhc_pkg::CAP_W) ? CNT_W : fkhc_pkg::CAP_W;
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_ENTRIES - 1);
  localparam int DW = fkhc_pkg::DATA_W;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  // Entry stores, one row per ring slot.
  logic [DW-1:0] key_mem    [MAX_ENTRIES];
  logic [DW-1:0] handle_mem [MAX_ENTRIES];
  logic [DW-1:0] id_mem     [MAX_ENTRIES];

  logic [DW-1:0] rd_key_r, rd_handle_r, rd_id_r;

  fkhc_pkg::cmd_t cmd_r, cmd_nxt;
  logic [DW-1:0]  key_r, key_nxt;
  logic [DW-1:0]  handle_r, handle_nxt;
  logic [DW-1:0]  id_r, id_nxt;
  logic           cacheable_r, cacheable_nxt;

  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic              out_valid_r, out_valid_nxt;
  fkhc_pkg::kind_t   out_kind_r, out_kind_nxt;
  logic [DW-1:0]     out_handle_r, out_handle_nxt;
  logic [DW-1:0]     out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic [SUM_W-1:0] wsum;
  logic [IDX_W-1:0] wslot;
  logic [CMP_W-1:0] cap_eff;
  logic             out_free;

  // Read port: scan pointer or oldest slot.
  assign rd_addr = cmd.rd_oldest ? oldest_r : ptr_r;
  assign rd_en   = cmd.rd_issue || cmd.rd_oldest;

  // Slot after the newest entry; the sum stays below twice the depth.
  assign wsum  = SUM_W'(oldest_r) + SUM_W'(count_r);
  assign wslot = (wsum >= SUM_W'(MAX_ENTRIES)) ? IDX_W'(wsum - SUM_W'(MAX_ENTRIES))
                                               : IDX_W'(wsum);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      key_mem[wslot]    <= key_r;
      handle_mem[wslot] <= handle_r;
      id_mem[wslot]     <= id_r;
    end
    if (rd_en) begin
      rd_key_r    <= key_mem[rd_addr];
      rd_handle_r <= handle_mem[rd_addr];
      rd_id_r     <= id_mem[rd_addr];
    end
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    handle_nxt    = handle_r;
    id_nxt        = id_r;
    cacheable_nxt = cacheable_r;
    if (cmd.latch_in) begin
      cmd_nxt       = fkhc_pkg::cmd_t'(in_command);
      key_nxt       = in_key;
      handle_nxt    = in_handle;
      id_nxt        = in_id;
      cacheable_nxt = !in_blend && (in_stream_id != fkhc_pkg::STREAM_NONE) &&
                      (in_key != '0);
    end
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    left_nxt   = left_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    if (cmd.scan_start) begin
      ptr_nxt  = oldest_r;
      left_nxt = count_r;
    end else if (cmd.rd_issue) begin
      ptr_nxt  = next_slot(ptr_r);
      left_nxt = left_r - 1'b1;
    end
    if (cmd.evict) begin
      oldest_nxt = next_slot(oldest_r);
      count_nxt  = count_r - 1'b1;
    end else if (cmd.store) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.clr_done) begin
      oldest_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_handle_nxt = out_handle_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = cmd.out_kind;
      out_last_nxt  = cmd.out_last;
      case (cmd.out_src)
        fkhc_pkg::SRC_RD_HANDLE: begin
          out_handle_nxt = rd_handle_r;
          out_id_nxt     = '0;
        end
        fkhc_pkg::SRC_RD_BOTH: begin
          out_handle_nxt = rd_handle_r;
          out_id_nxt     = rd_id_r;
        end
        fkhc_pkg::SRC_IN_HANDLE: begin
          out_handle_nxt = handle_r;
          out_id_nxt     = '0;
        end
        default: begin
          out_handle_nxt = '0;
          out_id_nxt     = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    handle_r     <= handle_nxt;
    id_r         <= id_nxt;
    cacheable_r  <= cacheable_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      left_r      <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      left_r      <= left_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.cacheable = cacheable_r;
  assign stat.handle_nz = (handle_r != '0);
  assign stat.key_match = (rd_key_r == key_r);
  assign stat.full      = (CMP_W'(count_r) >= cap_eff);
  assign stat.left_zero = (left_r == '0);
  assign stat.out_free  = out_free;

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_handle = out_handle_r;
  assign out_id     = out_id_r;
  assign out_last   = out_last_r;

  `FKHC_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(MAX_ENTRIES))
  `FKHC_ASSERT_IMPL(a_load_free, clk, rst_n, cmd.out_load, out_free)
  `FKHC_ASSERT_IMPL(a_evict_nonempty, clk, rst_n, cmd.evict, count_r != '0)
  `FKHC_ASSERT_NEXT(a_store_count, clk, rst_n, cmd.store, count_r == $past(count_r) + 1'b1)

endmodule

[src/fifo_keyed_handle_cache_core.sv]
// Top level of the keyed handle cache: channels, capacity register, controller and datapath.
`timescale 1ns / 1ps

// A fully associative cache mapping a 32-bit item key to a stored handle and
// resolved id, with oldest-first eviction. Each request item carries a command:
// a lookup returns one result (a hit with handle and id, or a miss), an insert
// returns an ignored result or a stored result, preceded by a release of the
// oldest entry when the store is at capacity, and a clear returns one release
// per stored entry, oldest first, and no result at all on an empty store. The
// final result of every request has last set. Lookups and inserts with a blend
// base, a stream id of all ones or a zero key bypass the cache. Entries live in
// a ring held in memories with one read and one write port, and a key search
// reads one entry per cycle, so the block works on one request at a time. The
// result of a lookup, or of an insert rejected by the key search, is loaded
// once the search ends and the output register is free; the search ends early
// on a hit, and a bypassed request skips it. An insert that stores searches the
// same way. When it evicts, the oldest entry is read and its release presented
// first, and the stored result follows once the release is taken. A clear
// reads and releases each stored entry in turn. A waiting result sits in an
// output register, so the next request is taken while it is still unclaimed.
// The capacity register (byte address 0) may be written only while the block
// is idle; a value of 0 acts as 1 and a value above MAX_ENTRIES acts as
// MAX_ENTRIES. Lowering the capacity below the current fill does not shed
// entries: each insert then evicts just one, and only a clear empties the store.
module fifo_keyed_handle_cache_core #(
  parameter int MAX_ENTRIES = fkhc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fkhc_in_if.sink                      in_item,
  fkhc_out_if.source                   out_item,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fkhc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [fkhc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [fkhc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  logic [fkhc_pkg::CAP_W-1:0]     capacity_r, capacity_nxt;
  logic [fkhc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic                           cfg_write;

  fkhc_pkg::dp_cmd_t  dp_cmd;
  fkhc_pkg::dp_stat_t dp_stat;

  // The register index sits above the byte offset within the 32-bit word.
  assign cfg_index  = cfg_paddr[fkhc_pkg::CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_write && (cfg_index == fkhc_pkg::CFG_REG_CAPACITY)) begin
      capacity_nxt = cfg_pwdata[fkhc_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= fkhc_pkg::CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // Reads of addresses beyond the register list return zero.
  assign cfg_prdata = (cfg_index == fkhc_pkg::CFG_REG_CAPACITY) ?
                      fkhc_pkg::CFG_DW'(capacity_r) : '0;

  // The controller sequences each request; the datapath holds the entries.
  fkhc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  fkhc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .capacity     (capacity_r),
    .in_command   (in_item.command),
    .in_blend     (in_item.blend_base_present),
    .in_stream_id (in_item.stream_id),
    .in_key       (in_item.item_key),
    .in_handle    (in_item.handle_in),
    .in_id        (in_item.id_in),
    .out_valid    (out_item.valid),
    .out_ready    (out_item.ready),
    .out_kind     (out_item.result_kind),
    .out_handle   (out_item.handle_out),
    .out_id       (out_item.id_out),
    .out_last     (out_item.last)
  );

endmodule
